>>> design/ktmp_pkg.sv
package ktmp_pkg;

  // Result field and its saturation limit
  localparam int PROFIT_W = 20;
  localparam int OUT_DATA_W = 24;
  localparam logic [PROFIT_W-1:0] PROFIT_MAX = 20'hFFFFF;

  // Register map
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_NUM_TRANSACTIONS = 3'd0;
  localparam int NUM_TRANS_W = 5;
  localparam logic [NUM_TRANS_W-1:0] NUM_TRANS_RESET = 5'd1;

  // Control that travels with each request down the cell chain
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } cell_ctrl_t;

endpackage

>>> design/ktmp_cell.sv
module ktmp_cell import ktmp_pkg::*; #(
  parameter int PRICE_BITS = 16,
  parameter int BAL_W = 22,
  parameter int K_W = 5,
  parameter int INDEX = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic [K_W-1:0]          k_sel,
  input  cell_ctrl_t              in_ctrl,
  input  logic [PRICE_BITS-1:0]   in_price,
  input  logic signed [BAL_W-1:0] in_sold,
  input  logic signed [BAL_W-1:0] in_result,
  output cell_ctrl_t              out_ctrl,
  output logic [PRICE_BITS-1:0]   out_price,
  output logic signed [BAL_W-1:0] out_sold,
  output logic signed [BAL_W-1:0] out_result
);

  localparam logic [K_W-1:0] MY_K = K_W'(INDEX + 1);

  logic signed [BAL_W-1:0] hold;
  logic signed [BAL_W-1:0] sold;
  logic signed [BAL_W-1:0] hold_next;
  logic signed [BAL_W-1:0] sold_next;
  logic signed [BAL_W-1:0] p_ext;
  logic signed [BAL_W-1:0] buy_val;
  logic signed [BAL_W-1:0] sell_val;

  assign p_ext = signed'({{(BAL_W-PRICE_BITS){1'b0}}, in_price});
  // in_sold is the sold balance of the cell below, already updated for this price
  assign buy_val = in_sold - p_ext;

  always_comb begin
    if (in_ctrl.first) begin
      hold_next = -p_ext;
    end else if (buy_val > hold) begin
      hold_next = buy_val;
    end else begin
      hold_next = hold;
    end
  end

  assign sell_val = hold_next + p_ext;

  always_comb begin
    if (in_ctrl.first) begin
      sold_next = '0;
    end else if (sell_val > sold) begin
      sold_next = sell_val;
    end else begin
      sold_next = sold;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_ctrl.valid) begin
      hold <= hold_next;
      sold <= sold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl.valid <= 1'b0;
    end else if (advance) begin
      out_ctrl.valid <= in_ctrl.valid;
    end
    if (advance) begin
      out_ctrl.first <= in_ctrl.first;
      out_ctrl.last  <= in_ctrl.last;
      out_price      <= in_price;
      out_sold       <= sold_next;
      out_result     <= (k_sel == MY_K) ? sold_next : in_result;
    end
  end

endmodule

>>> design/k_transaction_max_profit.sv
// k-transaction maximum profit over a stream of prices.
// Input channel s_*: one price per request in s_tdata, s_tlast marks the final
// price of a sequence. Output channel m_*: one request per sequence carrying
// the best profit with at most num_transactions buy/sell pairs, given when the
// last price has passed through the chain.
// Configuration: APB, num_transactions at address 0 (reset value 1, values
// above MAX_TRANSACTIONS act as MAX_TRANSACTIONS, 0 gives a profit of 0).
// Datapath: MAX_TRANSACTIONS cells, cell j holds the hold/sold balances of
// transaction j+1. A price walks one cell per cycle while the chain advances,
// passing through the cell registers in order, and the result of a sequence
// goes to the output register once its last price leaves the last cell.
// Throughput is one price per cycle while no result stalls the output, and
// every cell updates once per price. Reset empties the chain, clears the
// output valid and puts the block back to waiting for a first price. While a
// result waits on m_tready the whole chain stops and s_tready is low; it is
// ready again in the cycle the result is taken.
module k_transaction_max_profit import ktmp_pkg::*; #(
  parameter int MAX_TRANSACTIONS = 16,
  parameter int PRICE_BITS = 16,
  localparam int IN_DATA_W = ((PRICE_BITS + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  // s_tdata: price [PRICE_BITS-1:0], zero padding above
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [IN_DATA_W-1:0]        s_tdata,
  input  logic                        s_tlast,
  // m_tdata: max_profit [19:0], zero padding [23:20]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [OUT_DATA_W-1:0]       m_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [CFG_ADDR_W-1:0]       paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int BAL_W = PRICE_BITS + $clog2(MAX_TRANSACTIONS + 1) + 2;
  localparam int K_W = (MAX_TRANSACTIONS + 1 > 32) ? $clog2(MAX_TRANSACTIONS + 1) : NUM_TRANS_W;
  localparam int RES_W = (BAL_W > PROFIT_W + 2) ? BAL_W : PROFIT_W + 2;

  logic [NUM_TRANS_W-1:0] num_transactions;
  logic [K_W-1:0]         k_ext;
  logic [K_W-1:0]         k_sat;
  logic                   sequence_started;
  logic                   advance;

  cell_ctrl_t              link_ctrl   [MAX_TRANSACTIONS+1];
  logic [PRICE_BITS-1:0]   link_price  [MAX_TRANSACTIONS+1];
  logic signed [BAL_W-1:0] link_sold   [MAX_TRANSACTIONS+1];
  logic signed [BAL_W-1:0] link_result [MAX_TRANSACTIONS+1];

  logic signed [RES_W-1:0] res_ext;
  logic [PROFIT_W-1:0]     profit;
  logic [PROFIT_W-1:0]     max_profit;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_transactions <= NUM_TRANS_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_NUM_TRANSACTIONS) begin
      num_transactions <= pwdata[NUM_TRANS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_NUM_TRANSACTIONS) begin
      prdata[NUM_TRANS_W-1:0] = num_transactions;
    end
  end

  assign k_ext = K_W'(num_transactions);
  assign k_sat = (k_ext > K_W'(MAX_TRANSACTIONS)) ? K_W'(MAX_TRANSACTIONS) : k_ext;

  // The chain moves as a whole unless a result is stuck in the output register
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_started <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      sequence_started <= !s_tlast;
    end
  end

  assign link_ctrl[0].valid = s_tvalid;
  assign link_ctrl[0].first = !sequence_started;
  assign link_ctrl[0].last  = s_tlast;
  assign link_price[0]      = s_tdata[PRICE_BITS-1:0];
  assign link_sold[0]       = '0;
  assign link_result[0]     = '0;

  for (genvar j = 0; j < MAX_TRANSACTIONS; j++) begin : g_cell
    ktmp_cell #(
      .PRICE_BITS(PRICE_BITS),
      .BAL_W     (BAL_W),
      .K_W       (K_W),
      .INDEX     (j)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .k_sel     (k_sat),
      .in_ctrl   (link_ctrl[j]),
      .in_price  (link_price[j]),
      .in_sold   (link_sold[j]),
      .in_result (link_result[j]),
      .out_ctrl  (link_ctrl[j+1]),
      .out_price (link_price[j+1]),
      .out_sold  (link_sold[j+1]),
      .out_result(link_result[j+1])
    );
  end

  // Clamp the selected sold balance into the 20-bit result
  assign res_ext = RES_W'(link_result[MAX_TRANSACTIONS]);

  always_comb begin
    if (res_ext < 0) begin
      profit = '0;
    end else if (res_ext > signed'(RES_W'(PROFIT_MAX))) begin
      profit = PROFIT_MAX;
    end else begin
      profit = res_ext[PROFIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= link_ctrl[MAX_TRANSACTIONS].valid && link_ctrl[MAX_TRANSACTIONS].last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      max_profit <= profit;
    end
  end

  assign m_tdata = {{(OUT_DATA_W-PROFIT_W){1'b0}}, max_profit};

endmodule

>>> design/ktmp_checker.sv
module ktmp_checker import ktmp_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // A waiting result must not be overwritten or dropped
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Input stalls exactly while a result is blocked at the output
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:PROFIT_W] == '0)
    else $error("result padding not zero");

endmodule

bind k_transaction_max_profit ktmp_checker u_ktmp_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
